[sv/well44497b_prng_defines.svh]
// assertion macros used by well44497b_prng
`ifndef WELL44497B_PRNG_DEFINES_SVH
`define WELL44497B_PRNG_DEFINES_SVH

`ifndef ASSERT_OFF
`define W44B_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("w44b assertion failed");
`define W44B_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("w44b assertion failed");
`else
`define W44B_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define W44B_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

[sv/w44b_pkg.sv]
package w44b_pkg;

  localparam int WORD_W = 32;
  localparam int IDX_W  = 11;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // ring tap offsets
  localparam idx_t OFS_M1 = 11'd23;
  localparam idx_t OFS_M2 = 11'd481;
  localparam idx_t OFS_M3 = 11'd229;

  localparam word_t MASK_LOW  = 32'h0001_ffff;
  localparam word_t MASK_HIGH = 32'hfffe_0000;
  localparam word_t MIX_A     = 32'hb729_fcec;
  localparam word_t MIX_DS    = 32'hfbff_ffff;
  localparam word_t MIX_DT    = 32'h0002_0000;
  localparam word_t TEMPER_B  = 32'h93dd_1400;
  localparam word_t TEMPER_C  = 32'hfa11_8000;

  typedef struct packed {
    logic  vld;
    word_t data;
  } push_t;

endpackage

[sv/w44b_ram.sv]
module w44b_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1391,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/w44b_obuf.sv]
module w44b_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  w44b_pkg::push_t push,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop_ready,
  output w44b_pkg::word_t pop_data
);
  import w44b_pkg::*;

  word_t      ent_r [2];
  logic [1:0] cnt_r;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic       pop;

  assign pop_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign pop_data  = ent_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (push.vld) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push.vld && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push.vld) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      ent_r[wr_ptr_r] <= push.data;
    end
  end

endmodule

[sv/well44497b_prng.sv]
// WELL44497b pseudo-random word generator over a 1391-word ring.
// Input channel (in_valid/in_ready): in_mode 1 loads in_load_value at ring
// position in_load_index (positions past the ring end are dropped) and gives
// no word back; in_mode 0 generates one tempered word on the output channel.
// Output channel (out_valid/out_ready) carries out_random_word.
// The ring is kept as two copies of a 1391x32 RAM with one read port each and
// a shared write port; a generate item needs six reads, two per cycle, so an
// item occupies the read ports through phases PH_A, PH_B and PH_C, and no new
// item is taken before it ends; loads are taken every cycle while the output
// buffer is not full. A generate's result is pushed into that buffer in PH_C.
// The second write of a generate and the write of a load land in the first
// cycle of the following item; same-cycle address clashes are forwarded.
// Results go into a two-word output buffer; when it is full, in_ready drops
// until the receiver takes a word. Nothing is lost while out_ready is low.
// Reset clears the ring index to 0 and empties the output buffer; ring words
// keep no reset value and must be loaded before generating.
`include "well44497b_prng_defines.svh"

module well44497b_prng #(
  parameter int RING_WORDS = 1391
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [w44b_pkg::IDX_W-1:0]  in_load_index,
  input  logic [w44b_pkg::WORD_W-1:0] in_load_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [w44b_pkg::WORD_W-1:0] out_random_word
);
  import w44b_pkg::*;

  localparam int AW = $clog2(RING_WORDS);
  localparam logic [IDX_W:0] RING_EXT = (IDX_W+1)'(RING_WORDS);

  typedef enum logic [1:0] {PH_A, PH_B, PH_C} phase_t;

  function automatic idx_t idx_add(input idx_t i, input idx_t k);
    logic [IDX_W:0] s;
    s = {1'b0, i} + {1'b0, k};
    if (s >= RING_EXT) begin
      s = s - RING_EXT;
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic idx_t idx_sub(input idx_t i, input idx_t k);
    logic [IDX_W:0] s;
    s = {1'b0, i} + RING_EXT - {1'b0, k};
    if (s >= RING_EXT) begin
      s = s - RING_EXT;
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic word_t mix6(input word_t v);
    word_t r;
    r = {v[22:0], v[31:23]} & MIX_DS;
    if ((v & MIX_DT) != '0) begin
      r = r ^ MIX_A;
    end
    return r;
  endfunction

  function automatic word_t temper(input word_t x);
    word_t y;
    y = x ^ ((x << 7) & TEMPER_B);
    return y ^ ((y << 15) & TEMPER_C);
  endfunction

  phase_t phase_r;
  idx_t   idx_r;
  logic   mix_pend_r;
  logic   ld_pend_r;
  idx_t   ld_addr_r;
  word_t  ld_data_r;
  word_t  z1_r, z2_r, z3_r;
  logic   byp0_r, byp1_r;
  word_t  byp_data_r;

  idx_t   ra0, ra1, waddr;
  word_t  q0, q1, rd0, rd1, wdata;
  word_t  z0, z1, z2, z3, mixed;
  logic   we, accept, ob_full;
  push_t  ob_push;

  assign in_ready = (phase_r == PH_A) && !ob_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    case (phase_r)
      PH_A: begin
        ra0 = idx_r;
        ra1 = idx_add(idx_r, OFS_M1);
      end
      PH_B: begin
        ra0 = idx_add(idx_r, OFS_M2);
        ra1 = idx_add(idx_r, OFS_M3);
      end
      PH_C: begin
        ra0 = idx_sub(idx_r, IDX_W'(1));
        ra1 = idx_sub(idx_r, IDX_W'(2));
      end
      default: begin
        ra0 = idx_r;
        ra1 = idx_r;
      end
    endcase
  end

  // a write in the same cycle as a read of that entry is not seen by the ram
  assign rd0 = byp0_r ? byp_data_r : q0;
  assign rd1 = byp1_r ? byp_data_r : q1;

  assign z1    = (rd0 ^ (rd0 << 24)) ^ (rd1 ^ (rd1 >> 30));
  assign z2    = (rd0 ^ (rd0 << 10)) ^ (rd1 << 26);
  assign z3    = z1_r ^ z2;
  assign z0    = (rd0 & MASK_LOW) ^ (rd1 & MASK_HIGH);
  assign mixed = z0 ^ (z1_r ^ (z1_r >> 20)) ^ mix6(z2_r) ^ z3_r;

  // idx_r already points at i-1 when the mixed word is written
  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = z3;
    if (phase_r == PH_C) begin
      we = 1'b1;
    end else if (mix_pend_r) begin
      we    = 1'b1;
      wdata = mixed;
    end else if (ld_pend_r) begin
      we    = 1'b1;
      waddr = ld_addr_r;
      wdata = ld_data_r;
    end
  end

  assign ob_push.vld  = (phase_r == PH_C);
  assign ob_push.data = temper(z3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_A;
      idx_r      <= '0;
      mix_pend_r <= 1'b0;
      ld_pend_r  <= 1'b0;
      byp0_r     <= 1'b0;
      byp1_r     <= 1'b0;
    end else begin
      mix_pend_r <= 1'b0;
      ld_pend_r  <= 1'b0;
      byp0_r     <= we && (waddr == ra0);
      byp1_r     <= we && (waddr == ra1);
      case (phase_r)
        PH_A: begin
          if (accept && !in_mode) begin
            phase_r <= PH_B;
          end
          if (accept && in_mode && ({1'b0, in_load_index} < RING_EXT)) begin
            ld_pend_r <= 1'b1;
          end
        end
        PH_B: begin
          phase_r <= PH_C;
        end
        PH_C: begin
          phase_r    <= PH_A;
          idx_r      <= idx_sub(idx_r, IDX_W'(1));
          mix_pend_r <= 1'b1;
        end
        default: begin
          phase_r <= PH_A;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= wdata;
    if (accept) begin
      ld_addr_r <= in_load_index;
      ld_data_r <= in_load_value;
    end
    if (phase_r == PH_B) begin
      z1_r <= z1;
    end
    if (phase_r == PH_C) begin
      z2_r <= z2;
      z3_r <= z3;
    end
  end

  w44b_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RING_WORDS)
  ) u_ram0 (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(waddr)),
    .wdata (wdata),
    .raddr (AW'(ra0)),
    .rdata (q0)
  );

  w44b_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RING_WORDS)
  ) u_ram1 (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(waddr)),
    .wdata (wdata),
    .raddr (AW'(ra1)),
    .rdata (q1)
  );

  w44b_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ob_push),
    .full      (ob_full),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (out_random_word)
  );

  `W44B_ASSERT_IMP(a_one_writer, clk, rst_n, phase_r == PH_C, !mix_pend_r && !ld_pend_r)
  `W44B_ASSERT_IMP(a_tail_slot, clk, rst_n, mix_pend_r || ld_pend_r, phase_r == PH_A)
  `W44B_ASSERT_IMP(a_push_room, clk, rst_n, ob_push.vld, !ob_full)
  `W44B_ASSERT_NEXT(a_gen_start, clk, rst_n, accept && !in_mode, phase_r == PH_B)

endmodule
